/* src/dwsp_pkg.sv */
// ============================================================================
// dwsp_pkg
// Shared types, gain constants and the microcode program of the dual wheel
// speed pid core.
// ============================================================================
`default_nettype none

package dwsp_pkg;

   // coefficient operand of the shared multiplier
   localparam int COEF_W = 21;

   // Q0.24 gains, difference gains already scaled by the 50 Hz tick rate
   localparam logic signed [COEF_W-1:0] KP_FREE    = 21'sd838861;
   localparam logic signed [COEF_W-1:0] KP_LOAD    = 21'sd503316;
   localparam logic signed [COEF_W-1:0] KD_FREE_X  = 21'sd8400;
   localparam logic signed [COEF_W-1:0] KD_LOAD_X  = 21'sd25150;
   localparam logic signed [COEF_W-1:0] KI_PERIOD  = 21'sd220248;
   localparam logic signed [COEF_W-1:0] COEF_P_ONE = 21'sd1;
   localparam logic signed [COEF_W-1:0] COEF_N_ONE = -21'sd1;

   // integral term is split into a 24-bit low part and a signed high part
   localparam int ITERM_SPLIT = 24;
   localparam int ITERM_LIM_EXP = 56;
   localparam int ITERM_CLAMP_EXP = 57;
   localparam int HI_W = 33;

   // drive output format
   localparam int DRIVE_W = 16;
   localparam int DRIVE_SHIFT = 17;
   localparam int MOMENT_W = 16;

   // microcode program length
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_DONE  = 4'd14;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd15;

   typedef enum logic [1:0] {
      REG_TARGET_RIGHT = 2'd0,
      REG_TARGET_LEFT  = 2'd1,
      REG_MOMENT_DRIVE = 2'd2,
      REG_LOAD_MODE    = 2'd3
   } csr_index_type;

   typedef enum logic [0:0] {
      CH_RIGHT = 1'b0,
      CH_LEFT  = 1'b1
   } channel_type;

   typedef enum logic [2:0] {
      VAR_ERR,
      VAR_DIFF,
      VAR_LO,
      VAR_HI,
      VAR_MOM
   } var_sel_type;

   typedef enum logic [2:0] {
      COEF_KP,
      COEF_KD,
      COEF_KI,
      COEF_ONE,
      COEF_NEG
   } coef_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_L8,
      SH_R16,
      SH_L17
   } shift_type;

   typedef enum logic [1:0] {
      ITERM_NONE,
      ITERM_LO,
      ITERM_HI
   } iterm_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_RIGHT,
      FIN_LEFT
   } fin_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_ERROR,
      ACT_CLEAR
   } act_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_BR_CLEAR,
      SEQ_JUMP,
      SEQ_DONE
   } seq_type;

   typedef struct packed {
      var_sel_type        mul_var;
      coef_sel_type       mul_coef;
      channel_type        mul_ch;
      acc_op_type         acc_op;
      shift_type          acc_shift;
      iterm_type          acc_iterm;
      channel_type        acc_ch;
      fin_type            fin;
      act_type            act;
      seq_type            seq;
      logic [STEP_W-1:0]  target;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_word_type cw;
      cw.mul_var   = VAR_ERR;
      cw.mul_coef  = COEF_KP;
      cw.mul_ch    = CH_RIGHT;
      cw.acc_op    = ACC_NONE;
      cw.acc_shift = SH_NONE;
      cw.acc_iterm = ITERM_NONE;
      cw.acc_ch    = CH_RIGHT;
      cw.fin       = FIN_NONE;
      cw.act       = ACT_NONE;
      cw.seq       = SEQ_NEXT;
      cw.target    = STEP_DONE;
      case (step)
         4'd0: begin
            cw.seq    = SEQ_BR_CLEAR;
            cw.target = STEP_CLEAR;
         end
         4'd1: begin
            cw.act = ACT_ERROR;
         end
         4'd2: begin
            cw.mul_var  = VAR_ERR;
            cw.mul_coef = COEF_KP;
         end
         4'd3: begin
            cw.mul_var  = VAR_DIFF;
            cw.mul_coef = COEF_KD;
            cw.acc_op   = ACC_LOAD;
         end
         4'd4: begin
            cw.mul_var  = VAR_LO;
            cw.mul_coef = COEF_KI;
            cw.acc_op   = ACC_ADD;
         end
         4'd5: begin
            cw.mul_var   = VAR_HI;
            cw.mul_coef  = COEF_KI;
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_R16;
            cw.acc_iterm = ITERM_LO;
         end
         4'd6: begin
            cw.mul_var   = VAR_MOM;
            cw.mul_coef  = COEF_ONE;
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_L8;
            cw.acc_iterm = ITERM_HI;
         end
         4'd7: begin
            cw.mul_var   = VAR_ERR;
            cw.mul_coef  = COEF_KP;
            cw.mul_ch    = CH_LEFT;
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_L17;
         end
         4'd8: begin
            cw.mul_var  = VAR_DIFF;
            cw.mul_coef = COEF_KD;
            cw.mul_ch   = CH_LEFT;
            cw.acc_op   = ACC_LOAD;
            cw.acc_ch   = CH_LEFT;
            cw.fin      = FIN_RIGHT;
         end
         4'd9: begin
            cw.mul_var  = VAR_LO;
            cw.mul_coef = COEF_KI;
            cw.mul_ch   = CH_LEFT;
            cw.acc_op   = ACC_ADD;
            cw.acc_ch   = CH_LEFT;
         end
         4'd10: begin
            cw.mul_var   = VAR_HI;
            cw.mul_coef  = COEF_KI;
            cw.mul_ch    = CH_LEFT;
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_R16;
            cw.acc_iterm = ITERM_LO;
            cw.acc_ch    = CH_LEFT;
         end
         4'd11: begin
            cw.mul_var   = VAR_MOM;
            cw.mul_coef  = COEF_NEG;
            cw.mul_ch    = CH_LEFT;
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_L8;
            cw.acc_iterm = ITERM_HI;
            cw.acc_ch    = CH_LEFT;
         end
         4'd12: begin
            cw.acc_op    = ACC_ADD;
            cw.acc_shift = SH_L17;
            cw.acc_ch    = CH_LEFT;
         end
         4'd13: begin
            cw.fin = FIN_LEFT;
         end
         4'd14: begin
            cw.seq = SEQ_DONE;
         end
         4'd15: begin
            cw.act    = ACT_CLEAR;
            cw.seq    = SEQ_JUMP;
            cw.target = STEP_DONE;
         end
         default: begin
            cw.seq = SEQ_DONE;
         end
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

/* src/dual_wheel_speed_pid_core.sv */
// ============================================================================
// dual_wheel_speed_pid_core
// Two-channel wheel speed pid with moment drive offset and saturated drives.
// ============================================================================
`default_nettype none

// A control tick item carries the measured right and left wheel speeds
// (Q8.8 rad/s); the core forms the errors against the target registers,
// updates the saturating integrals and the previous errors, and returns one
// result item with both Q1.15 drives and a flag that is set when either drive
// was clamped. A clear item (tuser set) zeroes the history and returns zero
// drives. The core works on one item at a time; each item runs from acceptance
// to the result register under a 16-word microcode program that runs every
// product through one shared signed multiplier with a registered product and
// a single accumulator. The next item is accepted as soon as the program has
// handed its result to the output register, even while that result still
// waits to be taken; the program only pauses on its final step when the
// previous result is still unclaimed. The user must write the configuration
// registers through the csr port only while no item is in work; the core
// itself does not enforce this.
module dual_wheel_speed_pid_core
   import dwsp_pkg::*;
#(
   parameter int SPEED_WIDTH    = 16,
   parameter int INTEGRAL_WIDTH = 40
) (
   input  wire logic clock,
   input  wire logic reset,

   // configuration write port
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_addr,
   input  wire logic [((SPEED_WIDTH > MOMENT_W) ? SPEED_WIDTH : MOMENT_W)-1:0] csr_wdata,

   // request channel
   input  wire logic req_tvalid,
   output      logic req_tready,
   // tdata from bit 0: measured_right, measured_left, zero fill
   input  wire logic [((2*SPEED_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: opcode (1 = clear history)
   input  wire logic req_tuser,

   // response channel
   output      logic rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata from bit 0: drive_right, drive_left
   output      logic [2*DRIVE_W-1:0] rsp_tdata,
   // tuser: saturated
   output      logic rsp_tuser
);

   localparam int SW = SPEED_WIDTH;
   localparam int IW = INTEGRAL_WIDTH;
   localparam int ERR_W = SW + 1;
   localparam int DIFF_W = SW + 2;
   localparam int VAR_W = (DIFF_W > HI_W) ? DIFF_W : HI_W;
   localparam int PROD_W = VAR_W + COEF_W;
   localparam int ACC_W = (((SW + 21) > 59) ? (SW + 21) : 59) + 2;
   localparam int SUM_W = ((IW > ERR_W) ? IW : ERR_W) + 1;
   localparam int CMP_W = (IW > ITERM_LIM_EXP + 2) ? IW : ITERM_LIM_EXP + 2;

   localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [CMP_W-1:0] ITERM_LIM = CMP_W'(64'sd1 <<< ITERM_LIM_EXP);
   localparam logic signed [ACC_W-1:0] ITERM_CLAMP = ACC_W'(64'sd1 <<< ITERM_CLAMP_EXP);
   localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

   // saturating integral update
   function automatic logic signed [IW-1:0] integ_add(
      input logic signed [IW-1:0]    acc,
      input logic signed [ERR_W-1:0] e
   );
      logic signed [SUM_W-1:0] s;
      s = SUM_W'(acc) + SUM_W'(e);
      if (s > SUM_W'(I_MAX)) begin
         return I_MAX;
      end else if (s < SUM_W'(I_MIN)) begin
         return I_MIN;
      end
      return IW'(s);
   endfunction

   // configuration registers
   logic signed [SW-1:0]       target_r_ff, target_r_in;
   logic signed [SW-1:0]       target_l_ff, target_l_in;
   logic signed [MOMENT_W-1:0] moment_ff, moment_in;
   logic                       load_mode_ff, load_mode_in;

   // captured request
   logic                 opcode_ff, opcode_in;
   logic signed [SW-1:0] meas_r_ff, meas_r_in;
   logic signed [SW-1:0] meas_l_ff, meas_l_in;

   // controller history
   logic signed [ERR_W-1:0]  prev_r_ff, prev_r_in;
   logic signed [ERR_W-1:0]  prev_l_ff, prev_l_in;
   logic signed [IW-1:0]     integ_r_ff, integ_r_in;
   logic signed [IW-1:0]     integ_l_ff, integ_l_in;
   logic signed [DIFF_W-1:0] diff_r_ff, diff_r_in;
   logic signed [DIFF_W-1:0] diff_l_ff, diff_l_in;

   // datapath
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DRIVE_W-1:0] drive_r_ff, drive_r_in;
   logic signed [DRIVE_W-1:0] drive_l_ff, drive_l_in;
   logic                      sat_ff, sat_in;

   // sequencer
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2*DRIVE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   ucode_word_type           cw;
   logic                     accept;
   logic signed [ERR_W-1:0]  err_r, err_l;
   logic signed [IW-1:0]     mul_integ, acc_integ;
   logic signed [VAR_W-1:0]  mul_a;
   logic signed [COEF_W-1:0] mul_b;
   logic signed [ACC_W-1:0]  prod_ext, term;
   logic signed [CMP_W-1:0]  integ_cmp;
   logic                     huge_pos, huge_neg;
   logic signed [ACC_W-1:0]  q;
   logic signed [DRIVE_W-1:0] q_clamped;
   logic                     q_over;

   assign cw = ucode_rom(step_ff);
   assign req_tready = !busy_ff;
   assign accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // errors for the tick in work
   assign err_r = ERR_W'(target_r_ff) - ERR_W'(meas_r_ff);
   assign err_l = ERR_W'(target_l_ff) - ERR_W'(meas_l_ff);

   // multiplier operand selection
   assign mul_integ = (cw.mul_ch == CH_LEFT) ? integ_l_ff : integ_r_ff;

   always_comb begin
      case (cw.mul_var)
         VAR_ERR:  mul_a = (cw.mul_ch == CH_LEFT) ? VAR_W'(prev_l_ff) : VAR_W'(prev_r_ff);
         VAR_DIFF: mul_a = (cw.mul_ch == CH_LEFT) ? VAR_W'(diff_l_ff) : VAR_W'(diff_r_ff);
         VAR_LO:   mul_a = $signed(VAR_W'(mul_integ[ITERM_SPLIT-1:0]));
         VAR_HI:   mul_a = VAR_W'(mul_integ >>> ITERM_SPLIT);
         VAR_MOM:  mul_a = VAR_W'(moment_ff);
         default:  mul_a = '0;
      endcase
   end

   always_comb begin
      case (cw.mul_coef)
         COEF_KP:  mul_b = load_mode_ff ? KP_LOAD : KP_FREE;
         COEF_KD:  mul_b = load_mode_ff ? KD_LOAD_X : KD_FREE_X;
         COEF_KI:  mul_b = KI_PERIOD;
         COEF_ONE: mul_b = COEF_P_ONE;
         COEF_NEG: mul_b = COEF_N_ONE;
         default:  mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // accumulator term: scaled product, or the fixed value for a huge integral
   assign acc_integ = (cw.acc_ch == CH_LEFT) ? integ_l_ff : integ_r_ff;
   assign integ_cmp = CMP_W'(acc_integ);
   assign huge_pos = integ_cmp >= ITERM_LIM;
   assign huge_neg = integ_cmp <= -ITERM_LIM;
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (cw.acc_shift)
         SH_NONE: term = prod_ext;
         SH_L8:   term = prod_ext <<< 8;
         SH_R16:  term = prod_ext >>> 16;
         SH_L17:  term = prod_ext <<< DRIVE_SHIFT;
         default: term = prod_ext;
      endcase
      if (cw.acc_iterm == ITERM_LO) begin
         if (huge_pos) begin
            term = ITERM_CLAMP;
         end else if (huge_neg) begin
            term = -ITERM_CLAMP;
         end
      end else if (cw.acc_iterm == ITERM_HI) begin
         if (huge_pos || huge_neg) begin
            term = '0;
         end
      end
   end

   // floor to Q1.15 and clamp
   assign q = acc_ff >>> DRIVE_SHIFT;

   always_comb begin
      q_over = 1'b0;
      q_clamped = DRIVE_W'(q);
      if (q > Q_MAX) begin
         q_over = 1'b1;
         q_clamped = DRIVE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         q_over = 1'b1;
         q_clamped = DRIVE_W'(Q_MIN);
      end
   end

   // configuration writes
   always_comb begin
      target_r_in = target_r_ff;
      target_l_in = target_l_ff;
      moment_in = moment_ff;
      load_mode_in = load_mode_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_TARGET_RIGHT: target_r_in = csr_wdata[SW-1:0];
            REG_TARGET_LEFT:  target_l_in = csr_wdata[SW-1:0];
            REG_MOMENT_DRIVE: moment_in = csr_wdata[MOMENT_W-1:0];
            REG_LOAD_MODE:    load_mode_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // request capture, sequencer, history and datapath control
   always_comb begin
      opcode_in = opcode_ff;
      meas_r_in = meas_r_ff;
      meas_l_in = meas_l_ff;
      prev_r_in = prev_r_ff;
      prev_l_in = prev_l_ff;
      integ_r_in = integ_r_ff;
      integ_l_in = integ_l_ff;
      diff_r_in = diff_r_ff;
      diff_l_in = diff_l_ff;
      acc_in = acc_ff;
      drive_r_in = drive_r_ff;
      drive_l_in = drive_l_ff;
      sat_in = sat_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;

      if (accept) begin
         opcode_in = req_tuser;
         meas_r_in = req_tdata[SW-1:0];
         meas_l_in = req_tdata[2*SW-1:SW];
         busy_in = 1'b1;
         step_in = '0;
      end

      if (busy_ff) begin
         case (cw.act)
            ACT_ERROR: begin
               prev_r_in = err_r;
               prev_l_in = err_l;
               diff_r_in = DIFF_W'(prev_r_ff) - DIFF_W'(err_r);
               diff_l_in = DIFF_W'(prev_l_ff) - DIFF_W'(err_l);
               integ_r_in = integ_add(integ_r_ff, err_r);
               integ_l_in = integ_add(integ_l_ff, err_l);
               sat_in = 1'b0;
            end
            ACT_CLEAR: begin
               prev_r_in = '0;
               prev_l_in = '0;
               integ_r_in = '0;
               integ_l_in = '0;
               drive_r_in = '0;
               drive_l_in = '0;
               sat_in = 1'b0;
            end
            default: begin
            end
         endcase

         case (cw.acc_op)
            ACC_LOAD: acc_in = term;
            ACC_ADD:  acc_in = acc_ff + term;
            default: begin
            end
         endcase

         case (cw.fin)
            FIN_RIGHT: begin
               drive_r_in = q_clamped;
               sat_in = q_over;
            end
            FIN_LEFT: begin
               drive_l_in = q_clamped;
               sat_in = sat_ff || q_over;
            end
            default: begin
            end
         endcase

         case (cw.seq)
            SEQ_NEXT: step_in = step_ff + 1'b1;
            SEQ_BR_CLEAR: step_in = opcode_ff ? cw.target : step_ff + 1'b1;
            SEQ_JUMP: step_in = cw.target;
            SEQ_DONE: begin
               // hand over once the result register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = {drive_l_ff, drive_r_ff};
                  rsp_user_in = sat_ff;
                  busy_in = 1'b0;
               end
            end
            default: step_in = step_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_r_ff <= '0;
         target_l_ff <= '0;
         moment_ff <= '0;
         load_mode_ff <= 1'b0;
         prev_r_ff <= '0;
         prev_l_ff <= '0;
         integ_r_ff <= '0;
         integ_l_ff <= '0;
         busy_ff <= 1'b0;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_r_ff <= target_r_in;
         target_l_ff <= target_l_in;
         moment_ff <= moment_in;
         load_mode_ff <= load_mode_in;
         prev_r_ff <= prev_r_in;
         prev_l_ff <= prev_l_in;
         integ_r_ff <= integ_r_in;
         integ_l_ff <= integ_l_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      meas_r_ff <= meas_r_in;
      meas_l_ff <= meas_l_in;
      diff_r_ff <= diff_r_in;
      diff_l_ff <= diff_l_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      drive_r_ff <= drive_r_in;
      drive_l_ff <= drive_l_in;
      sat_ff <= sat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire
